@@ rtl/core/hswp_pkg.sv @@
// ----------------------------------------------------------------------------
// hswp_pkg
// Shared types and constants for the hunk stream word parser: parse phases,
// token kinds, hunk type codes, and the state and result records.
// ----------------------------------------------------------------------------
package hswp_pkg;

    // token kinds given with each result
    typedef enum logic [4:0] {
        KIND_IGNORED        = 5'd0,
        KIND_STREAM_END     = 5'd1,
        KIND_KNOWN_HUNK     = 5'd2,
        KIND_UNKNOWN_HUNK   = 5'd3,
        KIND_LENGTH         = 5'd4,
        KIND_PAYLOAD        = 5'd5,
        KIND_NAME           = 5'd6,
        KIND_TABLE_SIZE     = 5'd7,
        KIND_FIRST          = 5'd8,
        KIND_LAST           = 5'd9,
        KIND_HEADER_ENTRY   = 5'd10,
        KIND_RELOC_COUNT    = 5'd11,
        KIND_LIST_END       = 5'd12,
        KIND_RELOC_TARGET   = 5'd13,
        KIND_RELOC_OFFSET   = 5'd14,
        KIND_SYMBOL_ENTRY   = 5'd15,
        KIND_SYMBOL_VALUE   = 5'd16,
        KIND_COMMON_SIZE    = 5'd17,
        KIND_REF_COUNT      = 5'd18,
        KIND_REF_PAYLOAD    = 5'd19,
        KIND_SYMBOL_UNKNOWN = 5'd20
    } t_kind;

    // parse phase, one-hot
    typedef enum logic [20:0] {
        PH_TYPE       = 21'h000001,
        PH_LEN_BODY   = 21'h000002,
        PH_LEN_BSS    = 21'h000004,
        PH_LEN_NAME   = 21'h000008,
        PH_BODY       = 21'h000010,
        PH_NAME       = 21'h000020,
        PH_HDR_LEN    = 21'h000040,
        PH_HDR_NAME   = 21'h000080,
        PH_HDR_TSIZE  = 21'h000100,
        PH_HDR_FIRST  = 21'h000200,
        PH_HDR_LAST   = 21'h000400,
        PH_HDR_ENTRY  = 21'h000800,
        PH_REL_COUNT  = 21'h001000,
        PH_REL_TARGET = 21'h002000,
        PH_REL_OFFSET = 21'h004000,
        PH_SYM_ENTRY  = 21'h008000,
        PH_SYM_NAME   = 21'h010000,
        PH_SYM_VALUE  = 21'h020000,
        PH_SYM_COMMON = 21'h040000,
        PH_SYM_REFCNT = 21'h080000,
        PH_SYM_REFPAY = 21'h100000
    } t_phase;

    // hunk type codes (low 16 bits of a type word)
    localparam logic [15:0] HT_UNIT           = 16'h03E7;
    localparam logic [15:0] HT_NAME           = 16'h03E8;
    localparam logic [15:0] HT_CODE           = 16'h03E9;
    localparam logic [15:0] HT_DATA           = 16'h03EA;
    localparam logic [15:0] HT_BSS            = 16'h03EB;
    localparam logic [15:0] HT_RELOC32        = 16'h03EC;
    localparam logic [15:0] HT_RELOC16        = 16'h03ED;
    localparam logic [15:0] HT_RELOC8         = 16'h03EE;
    localparam logic [15:0] HT_EXTERNAL       = 16'h03EF;
    localparam logic [15:0] HT_SYMBOL         = 16'h03F0;
    localparam logic [15:0] HT_DEBUG          = 16'h03F1;
    localparam logic [15:0] HT_FINISH         = 16'h03F2;
    localparam logic [15:0] HT_HEADER         = 16'h03F3;
    localparam logic [15:0] HT_DREL32         = 16'h03F8;

    // symbol type codes: definitions run up to SYM_DEF_LAST
    localparam logic [7:0] SYM_DEF_LAST = 8'd3;
    localparam logic [7:0] SYM_REF32    = 8'd129;
    localparam logic [7:0] SYM_COMMON   = 8'd130;
    localparam logic [7:0] SYM_REF16    = 8'd131;
    localparam logic [7:0] SYM_REF8     = 8'd132;
    localparam logic [7:0] SYM_DREF32   = 8'd134;
    localparam logic [7:0] SYM_DREF16   = 8'd135;

    // parser state carried from word to word
    typedef struct packed {
        t_phase      phase;
        logic [31:0] words_left;
        logic [31:0] entry_counter;
        logic [15:0] current_hunk;
        logic [7:0]  saved_sym_kind;
        logic        stopped;
    } t_state;

    // one result token
    typedef struct packed {
        t_kind       kind;
        logic [15:0] hunk_kind;
        logic [31:0] word_value;
        logic [33:0] byte_size;
        logic [31:0] hunk_index;
        logic [1:0]  memory_flags;
        logic [7:0]  symbol_kind;
    } t_result;

endpackage

@@ rtl/core/hswp_step.sv @@
// ----------------------------------------------------------------------------
// hswp_step
// Single-word step of the parser: from the current state and one stream
// word, forms the result token and the next state.
// ----------------------------------------------------------------------------
module hswp_step (
    input  logic                    i_report_offsets,
    input  logic [31:0]             i_word,
    input  hswp_pkg::t_state        i_state,
    output hswp_pkg::t_state        o_next,
    output hswp_pkg::t_result       o_result
);

    logic [31:0]    words_dec;
    logic [7:0]     sym_kind_sel;
    logic           sym_known;
    hswp_pkg::t_phase after_sym_name;

    // shared decrement of the word counter
    assign words_dec = i_state.words_left - 32'd1;

    // symbol kind: freshly taken on an entry word, else the saved one
    assign sym_kind_sel = (i_state.phase == hswp_pkg::PH_SYM_ENTRY) ?
                          i_word[31:24] : i_state.saved_sym_kind;

    assign sym_known = (sym_kind_sel <= hswp_pkg::SYM_DEF_LAST) ||
                       (sym_kind_sel inside {hswp_pkg::SYM_REF32, hswp_pkg::SYM_COMMON,
                                             hswp_pkg::SYM_REF16, hswp_pkg::SYM_REF8,
                                             hswp_pkg::SYM_DREF32, hswp_pkg::SYM_DREF16});

    // phase that follows the name words of a symbol entry
    always_comb begin
        if (sym_kind_sel <= hswp_pkg::SYM_DEF_LAST) begin
            after_sym_name = hswp_pkg::PH_SYM_VALUE;
        end else if (sym_kind_sel == hswp_pkg::SYM_COMMON) begin
            after_sym_name = hswp_pkg::PH_SYM_COMMON;
        end else if (sym_known) begin
            after_sym_name = hswp_pkg::PH_SYM_REFCNT;
        end else begin
            after_sym_name = hswp_pkg::PH_SYM_ENTRY;
        end
    end

    // token and next state
    always_comb begin
        hswp_pkg::t_state  nxt;
        hswp_pkg::t_result res;
        nxt                  = i_state;
        res.kind             = hswp_pkg::KIND_IGNORED;
        res.hunk_kind        = i_state.current_hunk;
        res.word_value       = i_word;
        res.byte_size        = '0;
        res.hunk_index       = '0;
        res.memory_flags     = '0;
        res.symbol_kind      = '0;

        if (i_state.stopped) begin
            res.hunk_kind = '0;
        end else begin
            case (i_state.phase)
                hswp_pkg::PH_LEN_BODY, hswp_pkg::PH_LEN_BSS,
                hswp_pkg::PH_LEN_NAME, hswp_pkg::PH_HDR_LEN: begin
                    res.kind       = hswp_pkg::KIND_LENGTH;
                    res.byte_size  = {i_word, 2'b00};
                    nxt.words_left = i_word;
                    if (i_state.phase == hswp_pkg::PH_LEN_BSS || i_word == 32'd0) begin
                        nxt.phase = (i_state.phase == hswp_pkg::PH_HDR_LEN) ?
                                    hswp_pkg::PH_HDR_TSIZE : hswp_pkg::PH_TYPE;
                    end else if (i_state.phase == hswp_pkg::PH_LEN_BODY) begin
                        nxt.phase = hswp_pkg::PH_BODY;
                    end else if (i_state.phase == hswp_pkg::PH_LEN_NAME) begin
                        nxt.phase = hswp_pkg::PH_NAME;
                    end else begin
                        nxt.phase = hswp_pkg::PH_HDR_NAME;
                    end
                end
                hswp_pkg::PH_BODY, hswp_pkg::PH_NAME, hswp_pkg::PH_HDR_NAME: begin
                    res.kind = (i_state.phase == hswp_pkg::PH_BODY) ?
                               hswp_pkg::KIND_PAYLOAD : hswp_pkg::KIND_NAME;
                    nxt.words_left = words_dec;
                    if (words_dec == 32'd0) begin
                        nxt.phase = (i_state.phase == hswp_pkg::PH_HDR_NAME) ?
                                    hswp_pkg::PH_HDR_TSIZE : hswp_pkg::PH_TYPE;
                    end
                end
                hswp_pkg::PH_HDR_TSIZE: begin
                    res.kind       = hswp_pkg::KIND_TABLE_SIZE;
                    nxt.words_left = i_word;
                    nxt.phase      = hswp_pkg::PH_HDR_FIRST;
                end
                hswp_pkg::PH_HDR_FIRST: begin
                    res.kind          = hswp_pkg::KIND_FIRST;
                    nxt.entry_counter = i_word;
                    nxt.phase         = hswp_pkg::PH_HDR_LAST;
                end
                hswp_pkg::PH_HDR_LAST: begin
                    res.kind  = hswp_pkg::KIND_LAST;
                    nxt.phase = (i_state.words_left == 32'd0) ?
                                hswp_pkg::PH_TYPE : hswp_pkg::PH_HDR_ENTRY;
                end
                hswp_pkg::PH_HDR_ENTRY: begin
                    res.kind          = hswp_pkg::KIND_HEADER_ENTRY;
                    res.byte_size     = {8'd0, i_word[23:0], 2'b00};
                    res.hunk_index    = i_state.entry_counter;
                    res.memory_flags  = i_word[31:30];
                    nxt.entry_counter = i_state.entry_counter + 32'd1;
                    nxt.words_left    = words_dec;
                    if (words_dec == 32'd0) begin
                        nxt.phase = hswp_pkg::PH_TYPE;
                    end
                end
                hswp_pkg::PH_REL_COUNT: begin
                    if (i_word == 32'd0) begin
                        res.kind  = hswp_pkg::KIND_LIST_END;
                        nxt.phase = hswp_pkg::PH_TYPE;
                    end else begin
                        res.kind       = hswp_pkg::KIND_RELOC_COUNT;
                        nxt.words_left = i_word;
                        nxt.phase      = hswp_pkg::PH_REL_TARGET;
                    end
                end
                hswp_pkg::PH_REL_TARGET: begin
                    res.kind  = hswp_pkg::KIND_RELOC_TARGET;
                    nxt.phase = (i_state.words_left == 32'd0) ?
                                hswp_pkg::PH_REL_COUNT : hswp_pkg::PH_REL_OFFSET;
                end
                hswp_pkg::PH_REL_OFFSET: begin
                    res.kind = i_report_offsets ?
                               hswp_pkg::KIND_RELOC_OFFSET : hswp_pkg::KIND_PAYLOAD;
                    nxt.words_left = words_dec;
                    if (words_dec == 32'd0) begin
                        nxt.phase = hswp_pkg::PH_REL_COUNT;
                    end
                end
                hswp_pkg::PH_SYM_ENTRY: begin
                    if (i_word == 32'd0) begin
                        res.kind  = hswp_pkg::KIND_LIST_END;
                        nxt.phase = hswp_pkg::PH_TYPE;
                    end else begin
                        res.kind = sym_known ?
                                   hswp_pkg::KIND_SYMBOL_ENTRY : hswp_pkg::KIND_SYMBOL_UNKNOWN;
                        res.word_value     = {8'd0, i_word[23:0]};
                        res.symbol_kind    = i_word[31:24];
                        nxt.saved_sym_kind = i_word[31:24];
                        nxt.words_left     = {8'd0, i_word[23:0]};
                        nxt.phase = (i_word[23:0] == 24'd0) ?
                                    after_sym_name : hswp_pkg::PH_SYM_NAME;
                    end
                end
                hswp_pkg::PH_SYM_NAME: begin
                    res.kind       = hswp_pkg::KIND_NAME;
                    nxt.words_left = words_dec;
                    if (words_dec == 32'd0) begin
                        nxt.phase = after_sym_name;
                    end
                end
                hswp_pkg::PH_SYM_VALUE: begin
                    res.kind  = hswp_pkg::KIND_SYMBOL_VALUE;
                    nxt.phase = hswp_pkg::PH_SYM_ENTRY;
                end
                hswp_pkg::PH_SYM_COMMON: begin
                    res.kind  = hswp_pkg::KIND_COMMON_SIZE;
                    nxt.phase = hswp_pkg::PH_SYM_ENTRY;
                end
                hswp_pkg::PH_SYM_REFCNT: begin
                    res.kind       = hswp_pkg::KIND_REF_COUNT;
                    nxt.words_left = i_word;
                    nxt.phase = (i_word == 32'd0) ?
                                hswp_pkg::PH_SYM_ENTRY : hswp_pkg::PH_SYM_REFPAY;
                end
                hswp_pkg::PH_SYM_REFPAY: begin
                    res.kind       = hswp_pkg::KIND_REF_PAYLOAD;
                    nxt.words_left = words_dec;
                    if (words_dec == 32'd0) begin
                        nxt.phase = hswp_pkg::PH_SYM_ENTRY;
                    end
                end
                default: begin
                    // type word
                    if (i_word == 32'd0) begin
                        res.kind       = hswp_pkg::KIND_STREAM_END;
                        res.hunk_kind  = '0;
                        res.word_value = '0;
                        nxt.stopped    = 1'b1;
                        nxt.phase      = hswp_pkg::PH_TYPE;
                    end else begin
                        nxt.current_hunk = i_word[15:0];
                        res.hunk_kind    = i_word[15:0];
                        res.kind         = hswp_pkg::KIND_KNOWN_HUNK;
                        case (i_word[15:0])
                            hswp_pkg::HT_HEADER: nxt.phase = hswp_pkg::PH_HDR_LEN;
                            hswp_pkg::HT_CODE, hswp_pkg::HT_DATA,
                            hswp_pkg::HT_DEBUG: nxt.phase = hswp_pkg::PH_LEN_BODY;
                            hswp_pkg::HT_BSS: nxt.phase = hswp_pkg::PH_LEN_BSS;
                            hswp_pkg::HT_NAME, hswp_pkg::HT_UNIT:
                                nxt.phase = hswp_pkg::PH_LEN_NAME;
                            hswp_pkg::HT_RELOC32, hswp_pkg::HT_RELOC16,
                            hswp_pkg::HT_RELOC8, hswp_pkg::HT_DREL32:
                                nxt.phase = hswp_pkg::PH_REL_COUNT;
                            hswp_pkg::HT_EXTERNAL, hswp_pkg::HT_SYMBOL:
                                nxt.phase = hswp_pkg::PH_SYM_ENTRY;
                            hswp_pkg::HT_FINISH: nxt.phase = hswp_pkg::PH_TYPE;
                            default: begin
                                res.kind  = hswp_pkg::KIND_UNKNOWN_HUNK;
                                nxt.phase = hswp_pkg::PH_TYPE;
                            end
                        endcase
                    end
                end
            endcase
        end

        o_next   = nxt;
        o_result = res;
    end

endmodule

@@ rtl/core/hunk_stream_word_parser_core.sv @@
// ----------------------------------------------------------------------------
// hunk_stream_word_parser_core
// Classifies a hunk stream one 32-bit word per transaction and gives one
// token per word through a registered result stage.
// ----------------------------------------------------------------------------
// result: the token for an accepted word is registered and valid in the following cycle
// throughput: 1 word per cycle; a word is taken whenever the result register
//   is empty or its token is being taken in the same cycle
// reset: synchronous active low; parser returns to expecting a type word,
//   counters clear, offset reporting is off and the result register empties
module hunk_stream_word_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_word,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [4:0]  o_kind,
    output logic [15:0] o_hunk_kind,
    output logic [31:0] o_word_value,
    output logic [33:0] o_byte_size,
    output logic [31:0] o_hunk_index,
    output logic [1:0]  o_memory_flags,
    output logic [7:0]  o_symbol_kind
);

    hswp_pkg::t_state  r_state;
    hswp_pkg::t_state  n_state;
    hswp_pkg::t_result r_result;
    hswp_pkg::t_result n_result;
    logic              r_report_offsets;
    logic              r_out_valid;
    logic              in_acc;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;

    // per-word parse step
    hswp_step u_step (
        .i_report_offsets (r_report_offsets),
        .i_word           (i_word),
        .i_state          (r_state),
        .o_next           (n_state),
        .o_result         (n_result)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_offsets <= 1'b0;
        end else if (i_cfg_valid) begin
            r_report_offsets <= i_cfg_data;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase          <= hswp_pkg::PH_TYPE;
            r_state.words_left     <= '0;
            r_state.entry_counter  <= '0;
            r_state.current_hunk   <= '0;
            r_state.saved_sym_kind <= '0;
            r_state.stopped        <= 1'b0;
        end else if (in_acc) begin
            r_state <= n_state;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_result.kind;
    assign o_hunk_kind    = r_result.hunk_kind;
    assign o_word_value   = r_result.word_value;
    assign o_byte_size    = r_result.byte_size;
    assign o_hunk_index   = r_result.hunk_index;
    assign o_memory_flags = r_result.memory_flags;
    assign o_symbol_kind  = r_result.symbol_kind;

    // result register empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid after reset");

    // once stopped, the parser stays stopped
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.stopped |=> r_state.stopped)
        else $error("parser left stopped state");

    // words after the stream end are all ignored tokens
    a_stopped_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.stopped && in_acc) |=>
            (r_result.kind == hswp_pkg::KIND_IGNORED && r_result.hunk_kind == 16'd0))
        else $error("token after stream end not ignored");

    // a held result blocks new words
    a_hold_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("word taken while result held");

    // header entry sizes come from a 24-bit field
    a_hdr_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.kind == hswp_pkg::KIND_HEADER_ENTRY) |->
            (r_result.byte_size[33:26] == 8'd0))
        else $error("header entry size too wide");

endmodule
